[design/qte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and tables for the quaternion to Euler mapper.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;
    localparam int CW               = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK  = 3'd5;

    localparam logic signed [CW-1:0] ONE_Q30   = 64'sd1073741824;
    localparam logic signed [31:0]   DEG90_Q16 = 32'sd5898240;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_SUM,
        ST_SQRT,
        ST_PITCH,
        ST_YAW,
        ST_ROLL,
        ST_MAP,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_PITCH,
        SEL_YAW,
        SEL_ROLL
    } sel_t;

    typedef struct packed {
        logic load;
        logic prod;
        logic sum;
        logic sqrt_start;
        logic cordic_start;
        sel_t sel;
        logic map_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic cordic_done;
        logic map_done;
    } dp_sts_t;

    function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
        logic signed [31:0] r;
        unique case (i)
            5'd0: r = 32'sd2949120;
            5'd1: r = 32'sd1740967;
            5'd2: r = 32'sd919879;
            5'd3: r = 32'sd466945;
            5'd4: r = 32'sd234379;
            5'd5: r = 32'sd117304;
            5'd6: r = 32'sd58666;
            5'd7: r = 32'sd29335;
            5'd8: r = 32'sd14668;
            5'd9: r = 32'sd7334;
            5'd10: r = 32'sd3667;
            5'd11: r = 32'sd1833;
            5'd12: r = 32'sd917;
            5'd13: r = 32'sd458;
            5'd14: r = 32'sd229;
            5'd15: r = 32'sd115;
            5'd16: r = 32'sd57;
            5'd17: r = 32'sd29;
            5'd18: r = 32'sd14;
            5'd19: r = 32'sd7;
            5'd20: r = 32'sd4;
            5'd21: r = 32'sd2;
            5'd22: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

[design/qte_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_ctrl
// Sequencer: rate check, then steps the datapath through one sample.
// ----------------------------------------------------------------------------
module qte_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [31:0]      timestamp_us,
    input  logic [31:0]      min_interval,
    output logic             out_valid,
    input  logic             out_stall,
    input  qte_pkg::dp_sts_t sts,
    output qte_pkg::dp_cmd_t cmd
);
    import qte_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] last_reg, last_next;
    logic        once_reg, once_next;
    logic [31:0] ts_reg, ts_next;
    logic        valid_reg, valid_next;
    logic        drop;
    logic        take;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = valid_reg;
    assign take      = in_valid && !in_stall;
    assign drop      = (min_interval != 32'd0) && once_reg
                       && ((timestamp_us - last_reg) < min_interval);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= '0;
            once_reg  <= 1'b0;
            valid_reg <= 1'b0;
            ts_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            once_reg  <= once_next;
            valid_reg <= valid_next;
            ts_reg    <= ts_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        once_next  = once_reg;
        ts_next    = ts_reg;
        valid_next = valid_reg && out_stall;
        cmd        = '0;
        cmd.sel    = SEL_PITCH;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && !drop)
                begin
                    cmd.load   = 1'b1;
                    ts_next    = timestamp_us;
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.cordic_start = 1'b1;
                    state_next       = ST_PITCH;
                end
                else
                begin
                    cmd.sqrt_start = 1'b0;
                end
            end
            ST_PITCH:
            begin
                cmd.sel = SEL_PITCH;
                if (sts.cordic_done)
                begin
                    cmd.cordic_start = 1'b1;
                    cmd.sel          = SEL_YAW;
                    state_next       = ST_YAW;
                end
            end
            ST_YAW:
            begin
                cmd.sel = SEL_YAW;
                if (sts.cordic_done)
                begin
                    cmd.cordic_start = 1'b1;
                    cmd.sel          = SEL_ROLL;
                    state_next       = ST_ROLL;
                end
            end
            ST_ROLL:
            begin
                cmd.sel = SEL_ROLL;
                if (sts.cordic_done)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                cmd.map_step = 1'b1;
                if (sts.map_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    last_next    = ts_reg;
                    once_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (state_reg == ST_SUM)
        begin
            cmd.sqrt_start = 1'b1;
        end
    end

endmodule

[design/qte_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_datapath
// Products, bit-serial square root, shared CORDIC and per-axis mapping.
// ----------------------------------------------------------------------------
module qte_datapath #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  qte_pkg::dp_cmd_t       cmd,
    output qte_pkg::dp_sts_t       sts,
    input  logic signed [15:0]     quat_w,
    input  logic signed [15:0]     quat_x,
    input  logic signed [15:0]     quat_y,
    input  logic signed [15:0]     quat_z,
    input  logic signed [15:0]     yaw_gain,
    input  logic signed [15:0]     pitch_gain,
    input  logic signed [15:0]     roll_gain,
    input  logic [15:0]            dead_band,
    input  logic [2:0]             invert_mask,
    output logic signed [31:0]     yaw_deg,
    output logic signed [31:0]     pitch_deg,
    output logic signed [31:0]     roll_deg
);
    import qte_pkg::*;

    localparam int SW = $clog2(CORDIC_STEPS + 1);
    localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    logic signed [15:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [31:0] pwx_reg, pyz_reg, pwy_reg, pxz_reg, pwz_reg, pxy_reg;
    logic signed [31:0] pxx_reg, pyy_reg, pzz_reg;
    logic signed [CW-1:0] s_reg, ya_reg, yb_reg, ra_reg, rb_reg;
    logic signed [CW-1:0] s_raw;

    // square root
    logic [61:0] rem_reg;
    logic [61:0] res_reg;
    logic [61:0] bit_reg;
    logic        sq_busy_reg;
    logic [61:0] sum_rb;

    // CORDIC
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [31:0]   ang_reg;
    logic [SW-1:0]        it_reg;
    logic                 cb_busy_reg;
    sel_t                 cs_sel_reg;
    logic signed [31:0]   pitch_a_reg, yaw_a_reg, roll_a_reg;
    logic signed [CW-1:0] in_y, in_x;
    logic signed [CW-1:0] px, py;
    logic signed [31:0]   pang;
    logic                 zero_vec;
    logic signed [CW-1:0] dx, dy;
    logic [4:0]           tidx;

    // mapping
    logic [1:0]           m_reg;
    logic signed [31:0]   m_ang;
    logic signed [15:0]   m_gain;
    logic                 m_inv;
    logic signed [31:0]   m_mag;
    logic signed [31:0]   m_dz;
    logic signed [48:0]   m_prod;
    logic signed [49:0]   m_v;
    logic signed [31:0]   m_sat;
    logic signed [31:0]   yo_reg, po_reg, ro_reg;
    logic signed [31:0]   yq_reg, pq_reg, rq_reg;

    assign s_raw = (CW'(pwx_reg) - CW'(pyz_reg)) <<< 1;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg <= quat_w;
            x_reg <= quat_x;
            y_reg <= quat_y;
            z_reg <= quat_z;
        end
        if (cmd.prod)
        begin
            pwx_reg <= w_reg * x_reg;
            pyz_reg <= y_reg * z_reg;
            pwy_reg <= w_reg * y_reg;
            pxz_reg <= x_reg * z_reg;
            pwz_reg <= w_reg * z_reg;
            pxy_reg <= x_reg * y_reg;
            pxx_reg <= x_reg * x_reg;
            pyy_reg <= y_reg * y_reg;
            pzz_reg <= z_reg * z_reg;
        end
        if (cmd.sum)
        begin
            if (s_raw > ONE_Q30)
            begin
                s_reg <= ONE_Q30;
            end
            else if (s_raw < -ONE_Q30)
            begin
                s_reg <= -ONE_Q30;
            end
            else
            begin
                s_reg <= s_raw;
            end
            ya_reg <= (CW'(pwy_reg) + CW'(pxz_reg)) <<< 1;
            yb_reg <= ONE_Q30 - ((CW'(pxx_reg) + CW'(pyy_reg)) <<< 1);
            ra_reg <= (CW'(pwz_reg) + CW'(pxy_reg)) <<< 1;
            rb_reg <= ONE_Q30 - ((CW'(pxx_reg) + CW'(pzz_reg)) <<< 1);
        end
    end

    // sqrt(2^60 - s*s): s*s seen as 2^60 - (1-sn)(1+sn); compute radicand directly
    logic signed [CW-1:0] s_abs;
    logic [61:0]          rad;
    logic [31:0]          s_lo;
    assign s_abs = s_raw[CW-1] ? -s_raw : s_raw;
    assign s_lo  = 32'(s_abs > ONE_Q30 ? ONE_Q30 : s_abs);
    // (2^30 - a)(2^30 + a): two 33-bit factors, one multiply
    assign rad   = 62'((33'(32'h4000_0000) - 33'(s_lo)) * (33'(32'h4000_0000) + 33'(s_lo)));

    assign sum_rb = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
        end
        else if (cmd.sqrt_start)
        begin
            sq_busy_reg <= 1'b1;
        end
        else if (sq_busy_reg && bit_reg == '0)
        begin
            sq_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            rem_reg <= rad;
            res_reg <= '0;
            bit_reg <= 62'h1000_0000_0000_0000;
        end
        else if (sq_busy_reg && bit_reg != '0)
        begin
            if (rem_reg >= sum_rb)
            begin
                rem_reg <= rem_reg - sum_rb;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign sts.sqrt_done = sq_busy_reg && (bit_reg == '0);

    always_comb
    begin
        unique case (cmd.sel)
            SEL_YAW:
            begin
                in_y = ya_reg;
                in_x = yb_reg;
            end
            SEL_ROLL:
            begin
                in_y = ra_reg;
                in_x = rb_reg;
            end
            default:
            begin
                in_y = s_reg;
                in_x = CW'(res_reg);
            end
        endcase
        zero_vec = (in_x == '0) && (in_y == '0);
        px   = in_x;
        py   = in_y;
        pang = '0;
        if (in_x < 0)
        begin
            if (in_y >= 0)
            begin
                px   = in_y;
                py   = -in_x;
                pang = DEG90_Q16;
            end
            else
            begin
                px   = -in_y;
                py   = in_x;
                pang = -DEG90_Q16;
            end
        end
    end

    assign tidx = 5'(it_reg);
    assign dx   = cy_reg >>> it_reg;
    assign dy   = cx_reg >>> it_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cb_busy_reg <= 1'b0;
            it_reg      <= '0;
        end
        else if (cmd.cordic_start)
        begin
            cb_busy_reg <= 1'b1;
            it_reg      <= zero_vec ? SW'(NSTEPS) : '0;
        end
        else if (cb_busy_reg && it_reg != SW'(NSTEPS))
        begin
            it_reg <= it_reg + 1'b1;
        end
        else if (cb_busy_reg)
        begin
            cb_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cordic_start)
        begin
            cx_reg     <= px;
            cy_reg     <= py;
            ang_reg    <= zero_vec ? 32'sd0 : pang;
            cs_sel_reg <= cmd.sel;
        end
        else if (cb_busy_reg && it_reg != SW'(NSTEPS))
        begin
            if (cy_reg >= 0)
            begin
                cx_reg  <= cx_reg + dx;
                cy_reg  <= cy_reg - dy;
                ang_reg <= ang_reg + atan_deg(tidx);
            end
            else
            begin
                cx_reg  <= cx_reg - dx;
                cy_reg  <= cy_reg + dy;
                ang_reg <= ang_reg - atan_deg(tidx);
            end
        end
        if (cb_busy_reg && it_reg == SW'(NSTEPS))
        begin
            unique case (cs_sel_reg)
                SEL_YAW:  yaw_a_reg   <= ang_reg;
                SEL_ROLL: roll_a_reg  <= ang_reg;
                default:  pitch_a_reg <= ang_reg;
            endcase
        end
    end

    assign sts.cordic_done = cb_busy_reg && (it_reg == SW'(NSTEPS));

    // map one axis per cycle: yaw, pitch, roll
    always_comb
    begin
        unique case (m_reg)
            2'd1:
            begin
                m_ang = pitch_a_reg; m_gain = pitch_gain; m_inv = invert_mask[1];
            end
            2'd2:
            begin
                m_ang = roll_a_reg; m_gain = roll_gain; m_inv = invert_mask[2];
            end
            default:
            begin
                m_ang = yaw_a_reg; m_gain = yaw_gain; m_inv = invert_mask[0];
            end
        endcase
        m_mag  = m_ang[31] ? -m_ang : m_ang;
        m_dz   = ((dead_band != '0) && (m_mag < $signed({8'd0, dead_band, 8'd0})))
                 ? 32'sd0 : m_ang;
        m_prod = 49'(m_dz * m_gain) + 49'sd2048;
        m_v    = 50'(m_prod >>> 12);
        if (m_inv)
        begin
            m_v = -m_v;
        end
        if (m_v > 50'sd2147483647)
        begin
            m_sat = 32'sh7FFF_FFFF;
        end
        else if (m_v < -50'sd2147483648)
        begin
            m_sat = 32'sh8000_0000;
        end
        else
        begin
            m_sat = 32'(m_v);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= '0;
        end
        else if (cmd.map_step)
        begin
            m_reg <= (m_reg == 2'd2) ? 2'd0 : m_reg + 2'd1;
        end
    end

    assign sts.map_done = cmd.map_step && (m_reg == 2'd2);

    always_ff @(posedge clk)
    begin
        if (cmd.map_step)
        begin
            unique case (m_reg)
                2'd1:    pq_reg <= m_sat;
                2'd2:    rq_reg <= m_sat;
                default: yq_reg <= m_sat;
            endcase
        end
        if (cmd.out_load)
        begin
            yo_reg <= yq_reg;
            po_reg <= pq_reg;
            ro_reg <= rq_reg;
        end
    end

    assign yaw_deg   = yo_reg;
    assign pitch_deg = po_reg;
    assign roll_deg  = ro_reg;

endmodule

[design/quat_to_euler_axis_mapper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quat_to_euler_axis_mapper
// Quaternion to yaw/pitch/roll degrees with rate limit, deadzone and gain.
//
//   channel  signals                                 direction
//   in       in_valid/in_stall, quat_*, timestamp_us  sink
//   out      out_valid/out_stall, yaw/pitch/roll_deg  source
//   cfg      cfg_we, cfg_index, cfg_data              sink
//
// Samples are processed one at a time by the bit-serial square root and the
// one shared CORDIC unit, which resolves pitch, yaw and roll in turn. A
// dropped sample is discarded while the sequencer stays idle. The result
// register frees the datapath; a new sample is taken only when the sequencer
// is idle.
// Reset clears the registers to their defaults and the emit history.
// ----------------------------------------------------------------------------
module quat_to_euler_axis_mapper #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [15:0]               quat_w,
    input  logic signed [15:0]               quat_x,
    input  logic signed [15:0]               quat_y,
    input  logic signed [15:0]               quat_z,
    input  logic [31:0]                      timestamp_us,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [31:0]               yaw_deg,
    output logic signed [31:0]               pitch_deg,
    output logic signed [31:0]               roll_deg,
    input  logic                             cfg_we,
    input  logic [qte_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qte_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import qte_pkg::*;

    logic [31:0]        min_interval_reg;
    logic signed [15:0] yaw_gain_reg, pitch_gain_reg, roll_gain_reg;
    logic [15:0]        dead_band_reg;
    logic [2:0]         invert_reg;
    dp_cmd_t            cmd;
    dp_sts_t            sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= '0;
            yaw_gain_reg     <= 16'sd4096;
            pitch_gain_reg   <= 16'sd4096;
            roll_gain_reg    <= 16'sd4096;
            dead_band_reg    <= '0;
            invert_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                REG_YAW_GAIN:     yaw_gain_reg     <= cfg_data[15:0];
                REG_PITCH_GAIN:   pitch_gain_reg   <= cfg_data[15:0];
                REG_ROLL_GAIN:    roll_gain_reg    <= cfg_data[15:0];
                REG_DEAD_BAND:    dead_band_reg    <= cfg_data[15:0];
                REG_INVERT_MASK:  invert_reg       <= cfg_data[2:0];
                default:          ;
            endcase
        end
    end

    qte_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .timestamp_us (timestamp_us),
        .min_interval (min_interval_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    qte_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .quat_w       (quat_w),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .yaw_gain     (yaw_gain_reg),
        .pitch_gain   (pitch_gain_reg),
        .roll_gain    (roll_gain_reg),
        .dead_band    (dead_band_reg),
        .invert_mask  (invert_reg),
        .yaw_deg      (yaw_deg),
        .pitch_deg    (pitch_deg),
        .roll_deg     (roll_deg)
    );

endmodule
